>>> rtl/apba_pkg.sv
`default_nettype none

package apba_pkg;

  // Moving-average window
  localparam int AVG_DEPTH = 6;
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = SAMPLE_W + $clog2(AVG_DEPTH);
  localparam int POS_W     = $clog2(AVG_DEPTH);
  localparam int FILL_W    = $clog2(AVG_DEPTH + 1);

  // Average by reciprocal multiply: floor(sum * AVG_RECIP >> AVG_SHIFT) is exact
  // for every sum below 2^SUM_W
  localparam int AVG_SHIFT  = SUM_W + $clog2(AVG_DEPTH);
  localparam int AVG_RECIP  = ((1 << AVG_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam int RECIP_W    = SUM_W + 1;
  localparam int AVG_PROD_W = SUM_W + RECIP_W;

  // Datapath widths
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int ANGLE_W   = 15;
  localparam int DELTA_W   = 16;
  localparam int INTEG_W   = 32;
  localparam int ACC_W     = 35;
  localparam int FRAC_W    = 8;

  // Shared multiplier: unsigned gain times signed error term
  localparam int MUL_A_W   = 19;
  localparam int MUL_B_W   = DIFF_W;
  localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W;
  localparam int SCALED_W  = MUL_P_W - FRAC_W;

  // Restoring divider for the period, one quotient bit per cycle
  localparam int DIV_W     = 29;
  localparam int DEN_W     = 8;
  localparam int CNT_W     = $clog2(DIV_W + 1);

  // Config port
  localparam int CFG_W     = 19;
  localparam int CFG_IDX_W = 3;

  // Register widths
  localparam int SETPOINT_W = 16;
  localparam int PGAIN_W    = 12;
  localparam int IGAIN_W    = 10;
  localparam int DGAIN_W    = 19;
  localparam int PERIOD_W   = 8;
  localparam int WINDOW_W   = 16;
  localparam int LIMIT_W    = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT     = 3'd0,
    REG_PROP_GAIN    = 3'd1,
    REG_INTEG_GAIN   = 3'd2,
    REG_DERIV_GAIN   = 3'd3,
    REG_LOOP_PERIOD  = 3'd4,
    REG_INTEG_WINDOW = 3'd5,
    REG_ANGLE_LIMIT  = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_D_LOAD,
    ST_D_DIV,
    ST_D_ADD,
    ST_CLAMP
  } state_t;

endpackage

`default_nettype wire

>>> rtl/averaged_pid_beam_angle.sv
`default_nettype none

// Channel   | Dir | Beat contents (low bit first)
// ----------+-----+------------------------------------------------------------
// s_axis    | in  | tdata: distance_sample[15:0]
// m_axis    | out | tdata: beam_angle[14:0], rotation_delta[30:15],
//           |     |        position_error[47:31]
// cfg       | in  | cfg_we / cfg_index / cfg_data, write only, no wait
//
// A sample that does not complete the averaging window is taken and s_axis stays ready.
// A sample that yields a result goes through the reciprocal-multiply average, the
// error, the P, I and D products on the shared multiplier, a divider load, the
// period division over DIV_W quotient bits, then add and clamp; its beat turns
// valid and s_axis is ready again in the same cycle, when the clamp step ends.
// rst is synchronous, clears state and window and restores the config defaults.
// A finished result sits in the output register; s_axis is not ready while
// a result is being worked on, and the clamp step waits for a stalled m_axis.

module averaged_pid_beam_angle (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [apba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [apba_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [15:0]                    s_axis_tdata,   // distance_sample[15:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [47:0]                    m_axis_tdata    // beam_angle, rotation_delta,
                                                         // position_error
);
  import apba_pkg::*;

  state_t state, state_next;

  // Config registers
  logic [SETPOINT_W-1:0] setpoint;
  logic [PGAIN_W-1:0]    prop_gain;
  logic [IGAIN_W-1:0]    integ_gain;
  logic [DGAIN_W-1:0]    deriv_gain;
  logic [PERIOD_W-1:0]   loop_period;
  logic [WINDOW_W-1:0]   integ_window;
  logic [LIMIT_W-1:0]    angle_limit;

  // Sample window and running sum
  logic [SAMPLE_W-1:0] sample_window [AVG_DEPTH];
  logic [SUM_W-1:0]    run_sum, run_sum_next;
  logic [FILL_W-1:0]   fill_count, fill_next;
  logic [POS_W-1:0]    wpos;

  // Average
  logic [AVG_PROD_W-1:0] avg_prod;
  logic [SAMPLE_W-1:0]   avg_r;

  // Controller state
  logic signed [ERR_W-1:0]   previous_error;
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ANGLE_W-1:0] current_angle;

  // Working registers
  logic signed [ERR_W-1:0]   err_r;
  logic signed [DIFF_W-1:0]  diff_r;
  logic                      win_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [ACC_W-1:0]   acc;

  // Shared multiplier
  logic [MUL_A_W-1:0]         mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_prod, mul_q;
  logic signed [SCALED_W-1:0] mul_scaled;

  // Period divider
  logic [DIV_W-1:0] div_num;
  logic [DEN_W-1:0] div_rem, div_den, div_rem_next;
  logic [DEN_W:0]   div_trial;
  logic             div_ge, div_neg, div_step;
  logic [CNT_W-1:0] div_cnt;

  // Output register
  logic signed [ANGLE_W-1:0] beam_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic signed [ERR_W-1:0]   err_q;

  logic                      accept, out_free, out_load;
  logic [ERR_W-1:0]          err_mag;
  logic signed [INTEG_W:0]   isum_wide;
  logic signed [INTEG_W-1:0] isum_sat;
  logic signed [SCALED_W-1:0] dquot;
  logic signed [ACC_W-1:0]   lim_pos, lim_neg, clamped;
  logic signed [ANGLE_W-1:0] target;
  logic signed [DELTA_W-1:0] delta;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Running sum: drop the overwritten sample, add the new one
  assign run_sum_next = run_sum - SUM_W'(sample_window[wpos]) + SUM_W'(s_axis_tdata);
  assign fill_next    = (fill_count == FILL_W'(AVG_DEPTH)) ? fill_count
                                                           : fill_count + 1'b1;

  // Window average as a constant reciprocal multiply
  assign avg_prod = AVG_PROD_W'(run_sum) * AVG_PROD_W'(AVG_RECIP);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept && fill_next == FILL_W'(AVG_DEPTH)) state_next = ST_AVG;
      ST_AVG:    state_next = ST_ERR;
      ST_ERR:    state_next = ST_MUL_P;
      ST_MUL_P:  state_next = ST_MUL_I;
      ST_MUL_I:  state_next = ST_MUL_D;
      ST_MUL_D:  state_next = ST_D_LOAD;
      ST_D_LOAD: state_next = ST_D_DIV;
      ST_D_DIV:  if (div_cnt == CNT_W'(1)) state_next = ST_D_ADD;
      ST_D_ADD:  state_next = ST_CLAMP;
      ST_CLAMP:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_step      = 1'b0;
    out_load      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_MUL_P: begin
        mul_a = MUL_A_W'(prop_gain);
        mul_b = MUL_B_W'(err_r);
      end
      ST_MUL_I: begin
        mul_a = MUL_A_W'(integ_gain);
        mul_b = MUL_B_W'(err_r);
      end
      ST_MUL_D: begin
        mul_a = MUL_A_W'(deriv_gain);
        mul_b = diff_r;
      end
      ST_D_DIV: div_step = 1'b1;
      ST_CLAMP: out_load = out_free;
      default: ;
    endcase
  end

  // Multiplier and its floor-scaled product
  assign mul_prod   = $signed({1'b0, mul_a}) * mul_b;
  assign mul_scaled = mul_q[MUL_P_W-1:FRAC_W];

  // Restoring divider step
  assign div_trial    = {div_rem, div_num[DIV_W-1]};
  assign div_ge       = div_trial >= {1'b0, div_den};
  assign div_rem_next = div_ge ? DEN_W'(div_trial - {1'b0, div_den}) : div_trial[DEN_W-1:0];

  // Floor quotient: negative numerators were divided as their complement
  assign dquot = div_neg ? ~$signed({1'b0, div_num}) : $signed({1'b0, div_num});

  // Integral update with 32-bit saturation
  assign err_mag   = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
  assign isum_wide = (INTEG_W+1)'(integral_sum) + (INTEG_W+1)'(mul_scaled);
  always_comb begin
    if (isum_wide[INTEG_W] != isum_wide[INTEG_W-1])
      isum_sat = isum_wide[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                    : {1'b0, {(INTEG_W-1){1'b1}}};
    else
      isum_sat = isum_wide[INTEG_W-1:0];
  end

  // Angle clamp and delta
  assign lim_pos = $signed(ACC_W'(angle_limit));
  assign lim_neg = -lim_pos;
  always_comb begin
    if (acc > lim_pos)      clamped = lim_pos;
    else if (acc < lim_neg) clamped = lim_neg;
    else                    clamped = acc;
  end
  assign target = clamped[ANGLE_W-1:0];
  assign delta  = DELTA_W'(target) - DELTA_W'(current_angle);

  // Control state, config and controller memory
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      setpoint       <= SETPOINT_W'(2500);
      prop_gain      <= PGAIN_W'(512);
      integ_gain     <= IGAIN_W'(51);
      deriv_gain     <= DGAIN_W'(25600);
      loop_period    <= PERIOD_W'(10);
      integ_window   <= WINDOW_W'(200);
      angle_limit    <= LIMIT_W'(3500);
      for (int i = 0; i < AVG_DEPTH; i++) sample_window[i] <= '0;
      run_sum        <= '0;
      fill_count     <= '0;
      wpos           <= '0;
      previous_error <= '0;
      integral_sum   <= '0;
      current_angle  <= '0;
      div_cnt        <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_SETPOINT:     setpoint     <= cfg_data[SETPOINT_W-1:0];
          REG_PROP_GAIN:    prop_gain    <= cfg_data[PGAIN_W-1:0];
          REG_INTEG_GAIN:   integ_gain   <= cfg_data[IGAIN_W-1:0];
          REG_DERIV_GAIN:   deriv_gain   <= cfg_data[DGAIN_W-1:0];
          REG_LOOP_PERIOD:  loop_period  <= cfg_data[PERIOD_W-1:0];
          REG_INTEG_WINDOW: integ_window <= cfg_data[WINDOW_W-1:0];
          REG_ANGLE_LIMIT:  angle_limit  <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        sample_window[wpos] <= s_axis_tdata;
        run_sum             <= run_sum_next;
        fill_count          <= fill_next;
        wpos                <= (wpos == POS_W'(AVG_DEPTH - 1)) ? '0 : wpos + 1'b1;
      end

      // Divider step counter
      if (state == ST_D_LOAD)
        div_cnt <= CNT_W'(DIV_W);
      else if (div_step)
        div_cnt <= div_cnt - 1'b1;

      if (out_load) begin
        current_angle  <= target;
        previous_error <= err_r;
        integral_sum   <= integ_r;
      end

      if (out_load)
        m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)
        m_axis_tvalid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mul_q <= mul_prod;

    // Divider operands and steps
    if (div_step) begin
      div_num <= {div_num[DIV_W-2:0], div_ge};
      div_rem <= div_rem_next;
    end else if (state == ST_D_LOAD) begin
      div_neg <= mul_scaled[SCALED_W-1];
      div_num <= mul_scaled[SCALED_W-1] ? ~mul_scaled[DIV_W-1:0] : mul_scaled[DIV_W-1:0];
      div_rem <= '0;
      div_den <= (loop_period == '0) ? DEN_W'(1) : loop_period;
    end

    case (state)
      ST_AVG:
        avg_r <= avg_prod[AVG_SHIFT +: SAMPLE_W];
      ST_ERR:
        err_r <= $signed({1'b0, setpoint}) - $signed({1'b0, avg_r});
      ST_MUL_P: begin
        diff_r <= DIFF_W'(err_r) - DIFF_W'(previous_error);
        win_r  <= err_mag < ERR_W'(integ_window);
      end
      // P term lands in the accumulator
      ST_MUL_I:  acc <= ACC_W'(current_angle) + ACC_W'(mul_scaled);
      ST_MUL_D:  integ_r <= win_r ? isum_sat : '0;
      ST_D_LOAD: acc <= acc + ACC_W'(integ_r);
      ST_D_ADD:  acc <= acc + ACC_W'(dquot);
      default: ;
    endcase

    if (out_load) begin
      beam_q  <= target;
      delta_q <= delta;
      err_q   <= err_r;
    end
  end

  assign m_axis_tdata = {err_q, delta_q, beam_q};

endmodule

`default_nettype wire
